[rtl/core/monitor_frame_deframer_defines.svh]
// Assertion macros shared by the frame receiver modules.
`ifndef MONITOR_FRAME_DEFRAMER_DEFINES_SVH
`define MONITOR_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define MFD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame receiver assertion failed");

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define MFD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame receiver assertion failed");

`endif

[rtl/core/mfd_pkg.sv]
// Types and constants for the monitor frame receiver.
`timescale 1ns / 1ps
`default_nettype none
package mfd_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_MIN_FUNCTION = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH   = 8'd1;

    localparam logic [7:0] MIN_FUNCTION_RESET = 8'hF0;
    localparam logic [7:0] MAX_LENGTH_RESET   = 8'hF0;

    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [1:0] STATUS_GOOD  = 2'd0;
    localparam logic [1:0] STATUS_BAD   = 2'd1;
    localparam logic [1:0] STATUS_ABORT = 2'd2;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2,
        PH_SUM  = 2'd3
    } phase_t;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] function_code;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [7:0] frame_length;
        logic [1:0] status;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [7:0] min_function_code;
        logic [7:0] max_length;
    } cfg_t;

endpackage
`default_nettype wire

[rtl/core/mfd_cfg_regs.sv]
// Configuration registers of the monitor frame receiver.
`timescale 1ns / 1ps
`default_nettype none
module mfd_cfg_regs
    import mfd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    logic [7:0] min_function_reg;
    logic [7:0] max_length_reg;

    assign cfg_ready = 1'b1;

    // Writes to an index beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_function_reg <= MIN_FUNCTION_RESET;
            max_length_reg   <= MAX_LENGTH_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MIN_FUNCTION: min_function_reg <= cfg_data[7:0];
                REG_MAX_LENGTH:   max_length_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign cfg.min_function_code = min_function_reg;
    assign cfg.max_length        = max_length_reg;

endmodule
`default_nettype wire

[rtl/core/mfd_frame_core.sv]
// Frame phase tracking, checksum and result generation for one byte per beat.
`timescale 1ns / 1ps
`default_nettype none
`include "monitor_frame_deframer_defines.svh"
module mfd_frame_core
    import mfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output logic    res_valid,
    output result_t res
);

    phase_t     phase_reg,         phase_next;
    logic [7:0] held_function_reg, held_function_next;
    logic [7:0] held_length_reg,   held_length_next;
    logic [7:0] payload_count_reg, payload_count_next;
    logic [7:0] running_sum_reg,   running_sum_next;

    logic       timeout;
    logic [7:0] b;
    logic [7:0] sum_plus_b;

    assign timeout    = (item.command == CMD_TIMEOUT);
    assign b          = item.rx_byte;
    assign sum_plus_b = running_sum_reg + b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HUNT;
            held_function_reg <= 8'd0;
            held_length_reg   <= 8'd0;
            payload_count_reg <= 8'd0;
            running_sum_reg   <= 8'd0;
        end
        else if (fire)
        begin
            phase_reg         <= phase_next;
            held_function_reg <= held_function_next;
            held_length_reg   <= held_length_next;
            payload_count_reg <= payload_count_next;
            running_sum_reg   <= running_sum_next;
        end
    end

    always_comb
    begin
        phase_next         = phase_reg;
        held_function_next = held_function_reg;
        held_length_next   = held_length_reg;
        payload_count_next = payload_count_reg;
        running_sum_next   = running_sum_reg;

        res_valid         = 1'b0;
        res.kind          = KIND_VERDICT;
        res.function_code = held_function_reg;
        res.data_byte     = 8'd0;
        res.byte_index    = payload_count_reg;
        res.frame_length  = held_length_reg;
        res.status        = STATUS_ABORT;
        res.last          = 1'b1;

        case (phase_reg)
            PH_HUNT:
            begin
                if (!timeout && b >= cfg.min_function_code)
                begin
                    held_function_next = b;
                    held_length_next   = 8'd0;
                    payload_count_next = 8'd0;
                    running_sum_next   = b;
                    phase_next         = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (timeout || b > cfg.max_length)
                begin
                    // Abort during the length byte reports the rejected length, or zero on a timeout.
                    res_valid        = 1'b1;
                    res.byte_index   = 8'd0;
                    res.frame_length = timeout ? 8'd0 : b;
                    phase_next       = PH_HUNT;
                end
                else
                begin
                    held_length_next = b;
                    running_sum_next = sum_plus_b;
                    phase_next       = (b == 8'd0) ? PH_SUM : PH_DATA;
                end
            end
            PH_DATA:
            begin
                res_valid = 1'b1;
                if (timeout)
                begin
                    phase_next = PH_HUNT;
                end
                else
                begin
                    res.kind           = KIND_PAYLOAD;
                    res.data_byte      = b;
                    res.status         = STATUS_GOOD;
                    res.last           = 1'b0;
                    running_sum_next   = sum_plus_b;
                    payload_count_next = payload_count_reg + 8'd1;
                    // The advanced count decides whether the checksum byte comes next.
                    if (payload_count_next >= held_length_reg)
                    begin
                        phase_next = PH_SUM;
                    end
                end
            end
            default:
            begin
                res_valid  = 1'b1;
                phase_next = PH_HUNT;
                if (!timeout)
                begin
                    running_sum_next = sum_plus_b;
                    res.status       = (sum_plus_b == 8'd0) ? STATUS_GOOD : STATUS_BAD;
                end
            end
        endcase
    end

    `MFD_ASSERT_NXT(a_verdict_returns_to_hunt, fire && res_valid && res.kind == KIND_VERDICT, phase_reg == PH_HUNT)
    `MFD_ASSERT_IMP(a_payload_not_last, res_valid && res.kind == KIND_PAYLOAD, !res.last && res.status == STATUS_GOOD)
    `MFD_ASSERT_IMP(a_data_has_length, phase_reg == PH_DATA, held_length_reg != 8'd0)

endmodule
`default_nettype wire

[rtl/core/mfd_out_buf.sv]
// Two-entry result buffer that decouples the frame logic from the result consumer.
`timescale 1ns / 1ps
`default_nettype none
`include "monitor_frame_deframer_defines.svh"
module mfd_out_buf
    import mfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    space,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    result_t    mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign space        = (count_reg != 2'd2);
    assign result_valid = (count_reg != 2'd0);
    assign pop          = result_valid && result_ready;
    assign result       = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    `MFD_ASSERT_IMP(a_no_push_when_full, push, space)
    `MFD_ASSERT_IMP(a_count_bounded, 1'b1, count_reg != 2'd3)
    `MFD_ASSERT_IMP(a_pointers_track_count, count_reg == 2'd0 || count_reg == 2'd2, wr_ptr_reg == rd_ptr_reg)

endmodule
`default_nettype wire

[rtl/core/monitor_frame_deframer.sv]
// Monitor frame receiver: per-byte frame decode, one beat per cycle while the result buffer has space.
// An accepted byte is held in the stage register; its result, if any, enters the result buffer when the core fires.
// Throughput: one item per cycle while the result buffer has space, set by the phase update in the frame core.
// The two-entry result buffer keeps accepting items while a result waits to be taken, until both entries are full.
// Reset (rst_n low, asynchronous) restores the register defaults and the hunting phase.
`timescale 1ns / 1ps
`default_nettype none
module monitor_frame_deframer
    import mfd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  item_t                  item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg;
    logic    stage_valid_reg;
    item_t   stage_item_reg;
    logic    fire;
    logic    space;
    logic    res_valid;
    result_t res;

    assign fire       = stage_valid_reg && space;
    assign item_ready = !stage_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            stage_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            stage_item_reg <= item;
        end
    end

    mfd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mfd_frame_core u_frame_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (stage_item_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    mfd_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (fire && res_valid),
        .push_data    (res),
        .space        (space),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
`default_nettype wire

[tb/tb_monitor_frame_deframer.sv]
// Testbench for the monitor frame receiver: queued driver, checking monitor, frame decode predictor.
`timescale 1ns / 1ps
module tb_monitor_frame_deframer;
    import mfd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          REPORT_LIMIT = 10;

    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_SUM,
        FRAME_CUT,
        FRAME_OVERSIZE
    } frame_fault_t;

    logic                   clk;
    logic                   rst_n        = 1'b0;
    logic                   item_valid   = 1'b0;
    logic                   item_ready;
    item_t                  item         = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    result_t                result;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    item_t       pending_items[$];
    result_t     expected_results[$];
    int          sender_idle_pct    = 0;
    int          receiver_stall_pct = 0;
    int          error_count        = 0;
    int unsigned cycle_count        = 0;

    // Shadow of the receiver's registers and frame state.
    logic [7:0] shadow_min_function = MIN_FUNCTION_RESET;
    logic [7:0] shadow_max_length   = MAX_LENGTH_RESET;
    phase_t     rx_phase            = PH_HUNT;
    logic [7:0] cur_function        = '0;
    logic [7:0] cur_length          = '0;
    logic [7:0] cur_count           = '0;
    logic [7:0] cur_sum             = '0;

    monitor_frame_deframer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic result_t frame_result(logic kind, logic [7:0] data, logic [7:0] index,
                                             logic [7:0] len, logic [1:0] status, logic last);
        result_t r;
        r.kind          = kind;
        r.function_code = cur_function;
        r.data_byte     = data;
        r.byte_index    = index;
        r.frame_length  = len;
        r.status        = status;
        r.last          = last;
        return r;
    endfunction

    task automatic decode_item(input item_t it);
        logic       timeout;
        logic [7:0] b;
        timeout = (it.command == CMD_TIMEOUT);
        b       = it.rx_byte;
        case (rx_phase)
            PH_HUNT:
            begin
                if (!timeout && b >= shadow_min_function)
                begin
                    cur_function = b;
                    cur_length   = '0;
                    cur_count    = '0;
                    cur_sum      = b;
                    rx_phase     = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (timeout || b > shadow_max_length)
                begin
                    expected_results.push_back(frame_result(KIND_VERDICT, 8'd0, 8'd0,
                                                            timeout ? 8'd0 : b, STATUS_ABORT, 1'b1));
                    rx_phase = PH_HUNT;
                end
                else
                begin
                    cur_length = b;
                    cur_sum    = cur_sum + b;
                    rx_phase   = (b == 8'd0) ? PH_SUM : PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (timeout)
                begin
                    expected_results.push_back(frame_result(KIND_VERDICT, 8'd0, cur_count,
                                                            cur_length, STATUS_ABORT, 1'b1));
                    rx_phase = PH_HUNT;
                end
                else
                begin
                    expected_results.push_back(frame_result(KIND_PAYLOAD, b, cur_count,
                                                            cur_length, STATUS_GOOD, 1'b0));
                    cur_sum   = cur_sum + b;
                    cur_count = cur_count + 8'd1;
                    if (cur_count >= cur_length)
                        rx_phase = PH_SUM;
                end
            end
            default:
            begin
                if (timeout)
                begin
                    expected_results.push_back(frame_result(KIND_VERDICT, 8'd0, cur_count,
                                                            cur_length, STATUS_ABORT, 1'b1));
                end
                else
                begin
                    cur_sum = cur_sum + b;
                    expected_results.push_back(frame_result(KIND_VERDICT, 8'd0, cur_count,
                                                            cur_length,
                                                            (cur_sum == 8'd0) ? STATUS_GOOD
                                                                              : STATUS_BAD,
                                                            1'b1));
                end
                rx_phase = PH_HUNT;
            end
        endcase
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        bit      wrong;
        if (expected_results.size() == 0)
        begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("unexpected result beat: kind=%0d fc=%h data=%h idx=%h len=%h st=%0d last=%0d",
                         got.kind, got.function_code, got.data_byte, got.byte_index,
                         got.frame_length, got.status, got.last);
            return;
        end
        want  = expected_results.pop_front();
        wrong = (got.kind !== want.kind) || (got.function_code !== want.function_code) ||
                (got.data_byte !== want.data_byte) || (got.byte_index !== want.byte_index) ||
                (got.frame_length !== want.frame_length) || (got.status !== want.status) ||
                (got.last !== want.last);
        if (wrong)
        begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("result mismatch: expected kind=%0d fc=%h data=%h idx=%h len=%h st=%0d last=%0d, got kind=%0d fc=%h data=%h idx=%h len=%h st=%0d last=%0d",
                         want.kind, want.function_code, want.data_byte, want.byte_index,
                         want.frame_length, want.status, want.last,
                         got.kind, got.function_code, got.data_byte, got.byte_index,
                         got.frame_length, got.status, got.last);
        end
    endtask

    // Driver: a new beat is offered only once the previous one has been taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else
        begin
            if (item_valid && item_ready)
                decode_item(item);
            if (!item_valid || item_ready)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    item_valid <= 1'b1;
                    item       <= pending_items.pop_front();
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
                check_result(result);
            result_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_MIN_FUNCTION)
            shadow_min_function = val;
        else if (idx == REG_MAX_LENGTH)
            shadow_max_length = val;
    endtask

    // Returns once every queued beat is taken, every result is in, and the pipeline is empty.
    task automatic wait_drained();
        while (pending_items.size() > 0 || item_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_byte(input logic [7:0] b);
        item_t it;
        it.command = CMD_BYTE;
        it.rx_byte = b;
        pending_items.push_back(it);
    endtask

    task automatic push_timeout();
        item_t it;
        it.command = CMD_TIMEOUT;
        it.rx_byte = 8'($urandom);
        pending_items.push_back(it);
    endtask

    // Positions: 0 function code, 1 length, 2.. payload, len+2 checksum.
    task automatic push_frame(input logic [7:0] fc, input logic [7:0] len,
                              input frame_fault_t fault);
        logic [7:0] sum;
        logic [7:0] b;
        int         cut_at;
        int         pos;
        cut_at = (fault == FRAME_CUT) ? int'($urandom_range(int'(len) + 2, 1)) : -1;
        push_byte(fc);
        sum = fc;
        if (cut_at == 1)
        begin
            push_timeout();
            return;
        end
        push_byte(len);
        sum = sum + len;
        if (fault == FRAME_OVERSIZE)
            return;
        for (pos = 2; pos < int'(len) + 2; pos++)
        begin
            if (pos == cut_at)
            begin
                push_timeout();
                return;
            end
            b = 8'($urandom);
            push_byte(b);
            sum = sum + b;
        end
        if (cut_at == int'(len) + 2)
        begin
            push_timeout();
            return;
        end
        b = 8'd0 - sum;
        if (fault == FRAME_BAD_SUM)
            b = b + 8'($urandom_range(255, 1));
        push_byte(b);
    endtask

    // Mostly well-formed frames with random content; the rest have a bad checksum, are cut, oversized or noise.
    task automatic run_random(input int n_items);
        int           frame_items;
        int           queued_prior;
        int           sel;
        int           cap;
        logic [7:0]   fc;
        logic [7:0]   len;
        frame_fault_t fault;
        frame_items = 0;
        while (frame_items < n_items)
        begin
            sel = $urandom_range(99);
            if (sel >= 88)
            begin
                if (shadow_min_function > 8'd0 && $urandom_range(1) == 0)
                    push_byte(8'($urandom_range(int'(shadow_min_function) - 1, 0)));
                else
                    push_timeout();
            end
            else
            begin
                fc  = 8'($urandom_range(255, int'(shadow_min_function)));
                cap = (shadow_max_length < 8'd10) ? int'(shadow_max_length) : 10;
                if ($urandom_range(9) == 0)
                    cap = (shadow_max_length < 8'd24) ? int'(shadow_max_length) : 24;
                len = 8'($urandom_range(cap, 0));
                if ($urandom_range(7) == 0 && shadow_max_length <= 8'd24)
                    len = shadow_max_length;
                if (sel < 56)
                    fault = FRAME_GOOD;
                else if (sel < 70)
                    fault = FRAME_BAD_SUM;
                else if (sel < 80 || shadow_max_length == 8'hFF)
                    fault = FRAME_CUT;
                else
                begin
                    fault = FRAME_OVERSIZE;
                    len   = 8'($urandom_range(255, int'(shadow_max_length) + 1));
                end
                queued_prior = pending_items.size();
                push_frame(fc, len, fault);
                frame_items += pending_items.size() - queued_prior;
            end
        end
    endtask

    task automatic run_phase(input logic [7:0] min_fc, input logic [7:0] max_len,
                             input int sender_pct, input int receiver_pct, input int n_items);
        wait_drained();
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
        write_reg(REG_MIN_FUNCTION, min_fc);
        write_reg(REG_MAX_LENGTH, max_len);
        run_random(n_items);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the register defaults: ignored noise while hunting.
        push_byte(8'h00);
        push_byte(8'hEF);
        push_timeout();
        // Empty payload, then extreme payload bytes with a good checksum, then a frame with a bad checksum.
        push_frame(8'hF0, 8'd0, FRAME_GOOD);
        push_byte(8'hF0);
        push_byte(8'h02);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h0F);
        push_frame(8'hFF, 8'd1, FRAME_BAD_SUM);
        // Length one above the limit aborts with the rejected length.
        push_byte(8'hF3);
        push_byte(8'hF1);
        // Timeouts in the length, payload and checksum positions.
        push_byte(8'hFF);
        push_timeout();
        push_byte(8'hFA);
        push_byte(8'h03);
        push_byte(8'h55);
        push_timeout();
        push_byte(8'hF5);
        push_byte(8'h01);
        push_byte(8'hAA);
        push_timeout();

        run_phase(8'h00, 8'h00, 0, 0, 90);
        run_phase(8'hFF, 8'hFF, 60, 0, 80);
        push_frame(8'hFF, 8'hFF, FRAME_GOOD);
        run_phase(8'h40, 8'd12, 0, 60, 100);
        run_phase(8'($urandom), 8'($urandom), 9, 9, 100);

        // Writes to indexes past the register list must leave both registers alone.
        wait_drained();
        write_reg(8'd2, 8'($urandom));
        write_reg(8'hFF, 8'h00);
        write_reg(8'($urandom_range(254, 3)), 8'hFF);
        run_phase(MIN_FUNCTION_RESET, MAX_LENGTH_RESET, 0, 0, 90);
        run_phase(8'h01, 8'd5, 60, 60, 80);

        wait_drained();
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
